[rtl/core/itad_pkg.sv]
package itad_pkg;

    localparam int VALUE_BITS  = 31;
    localparam int MAX_DIGITS  = 10;
    localparam int CNT_W       = 4;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for any x below 2**32
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    localparam logic [DIGIT_W-1:0] DEC_BASE = 4'd10;
    localparam int HEX_SHIFT   = 4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_X = 8'h58;

    // register index is the word address, paddr[2]
    localparam logic REG_RADIX_MODE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_PREFIX_ZERO,
        ST_PREFIX_X,
        ST_EMIT
    } itad_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic hex;
    } itad_ctrl_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               final_digit;
    } itad_stat_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] wide;
        wide = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DEC_BASE)
            return CHAR_ZERO + wide;
        return CHAR_UPPER_A + wide - {{(CHAR_W-DIGIT_W){1'b0}}, DEC_BASE};
    endfunction

endpackage

[rtl/core/itad_digit_unit.sv]
module itad_digit_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  itad_pkg::itad_ctrl_t             ctrl,
    input  logic [itad_pkg::VALUE_BITS-1:0]  value,
    output itad_pkg::itad_stat_t             stat
);

    localparam int PROD_W = itad_pkg::VALUE_BITS + itad_pkg::RECIP_W;

    logic [itad_pkg::VALUE_BITS-1:0] work_reg;
    logic [itad_pkg::VALUE_BITS-1:0] work_next;
    logic [PROD_W-1:0]               product;
    logic [itad_pkg::VALUE_BITS-1:0] quot_dec;
    logic [itad_pkg::VALUE_BITS-1:0] quot_hex;
    logic [itad_pkg::VALUE_BITS-1:0] quot;
    logic [itad_pkg::DIGIT_W-1:0]    q_times_ten;
    logic [itad_pkg::DIGIT_W-1:0]    rem_dec;

    assign product  = {{itad_pkg::RECIP_W{1'b0}}, work_reg}
                    * {{itad_pkg::VALUE_BITS{1'b0}}, itad_pkg::RECIP_10};
    assign quot_dec = itad_pkg::VALUE_BITS'(product >> itad_pkg::RECIP_SHIFT);
    assign quot_hex = work_reg >> itad_pkg::HEX_SHIFT;

    // remainder is below ten, so the low nibble of x - 10q is exact
    assign q_times_ten = {quot_dec[0], 3'b000} + {quot_dec[2:0], 1'b0};
    assign rem_dec     = work_reg[itad_pkg::DIGIT_W-1:0] - q_times_ten;

    assign quot = ctrl.hex ? quot_hex : quot_dec;

    assign stat.digit       = ctrl.hex ? work_reg[itad_pkg::DIGIT_W-1:0] : rem_dec;
    assign stat.final_digit = (quot == '0);

    always_comb
    begin
        work_next = work_reg;
        if (ctrl.load)
            work_next = value;
        else if (ctrl.step)
            work_next = quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            work_reg <= '0;
        else
            work_reg <= work_next;
    end

endmodule

[rtl/core/itad_digit_store.sv]
module itad_digit_store (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [itad_pkg::CNT_W-1:0]     wr_idx,
    input  logic [itad_pkg::DIGIT_W-1:0]   wr_digit,
    input  logic [itad_pkg::CNT_W-1:0]     rd_idx,
    output logic [itad_pkg::DIGIT_W-1:0]   rd_digit
);

    logic [itad_pkg::DIGIT_W-1:0] store_reg [itad_pkg::MAX_DIGITS];

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx < itad_pkg::CNT_W'(itad_pkg::MAX_DIGITS)))
            store_reg[wr_idx] <= wr_digit;
    end

    assign rd_digit = (rd_idx < itad_pkg::CNT_W'(itad_pkg::MAX_DIGITS))
                    ? store_reg[rd_idx] : '0;

endmodule

[rtl/core/itad_seq.sv]
module itad_seq (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           radix_mode,
    input  itad_pkg::itad_stat_t           stat,
    input  logic [itad_pkg::DIGIT_W-1:0]   rd_digit,
    output itad_pkg::itad_ctrl_t           ctrl,
    output logic                           wr_en,
    output logic [itad_pkg::CNT_W-1:0]     wr_idx,
    output logic [itad_pkg::CNT_W-1:0]     rd_idx,
    output logic                           busy,
    output logic                           char_valid,
    output logic [itad_pkg::CHAR_W-1:0]    char_code,
    output logic                           last
);

    itad_pkg::itad_state_t          state_reg, state_next;
    logic [itad_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           hex_reg, hex_next;
    logic                           valid_reg, valid_next;
    logic [itad_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic                           last_reg, last_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itad_pkg::ST_IDLE:
                if (start)
                    state_next = itad_pkg::ST_EXTRACT;
            itad_pkg::ST_EXTRACT:
                if (stat.final_digit)
                    state_next = hex_reg ? itad_pkg::ST_PREFIX_ZERO : itad_pkg::ST_EMIT;
            itad_pkg::ST_PREFIX_ZERO:
                state_next = itad_pkg::ST_PREFIX_X;
            itad_pkg::ST_PREFIX_X:
                state_next = itad_pkg::ST_EMIT;
            itad_pkg::ST_EMIT:
                if (count_reg == itad_pkg::CNT_W'(1))
                    state_next = itad_pkg::ST_IDLE;
            default:
                state_next = itad_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.load  = 1'b0;
        ctrl.step  = 1'b0;
        ctrl.hex   = hex_reg;
        wr_en      = 1'b0;
        count_next = count_reg;
        hex_next   = hex_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        last_next  = 1'b0;
        unique case (state_reg)
            itad_pkg::ST_IDLE:
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    hex_next   = radix_mode;
                    count_next = '0;
                end
            itad_pkg::ST_EXTRACT:
            begin
                ctrl.step  = 1'b1;
                wr_en      = 1'b1;
                count_next = count_reg + itad_pkg::CNT_W'(1);
            end
            itad_pkg::ST_PREFIX_ZERO:
            begin
                valid_next = 1'b1;
                char_next  = itad_pkg::CHAR_ZERO;
            end
            itad_pkg::ST_PREFIX_X:
            begin
                valid_next = 1'b1;
                char_next  = itad_pkg::CHAR_UPPER_X;
            end
            itad_pkg::ST_EMIT:
            begin
                valid_next = 1'b1;
                char_next  = itad_pkg::digit_to_ascii(rd_digit);
                last_next  = (count_reg == itad_pkg::CNT_W'(1));
                count_next = count_reg - itad_pkg::CNT_W'(1);
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    // digits go in least significant first and come back out in reverse
    assign wr_idx = count_reg;
    assign rd_idx = count_reg - itad_pkg::CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itad_pkg::ST_IDLE;
            count_reg <= '0;
            hex_reg   <= 1'b0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            hex_reg   <= hex_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign busy       = (state_reg != itad_pkg::ST_IDLE);
    assign char_valid = valid_reg;
    assign char_code  = char_reg;
    assign last       = last_reg;

endmodule

[rtl/core/integer_to_ascii_digits_top.sv]
// Channel   Handshake                       Payload
// -------   -----------------------------   ----------------------------------
// config    psel/penable/pwrite, pready=1   paddr[2:0], pwdata/prdata (radix)
// request   start & !busy                   value[30:0]
// result    char_valid (one cycle)          char_code[7:0], last
//
// While a request is busy, the shared divide unit yields one digit a cycle, then
// the characters leave one a cycle: the prefix "0X" first in hex mode, then the
// digits. Each character shows on the result ports in the cycle after it is
// produced. Worst case: ten decimal digits.
// rst_n clears control state and the radix register; the digit store is not
// cleared. Results are never stalled.
module integer_to_ascii_digits_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [itad_pkg::ADDR_W-1:0]      paddr,
    input  logic [itad_pkg::DATA_W-1:0]      pwdata,
    output logic [itad_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    input  logic                             start,
    output logic                             busy,
    input  logic [itad_pkg::VALUE_BITS-1:0]  value,
    output logic                             char_valid,
    output logic [itad_pkg::CHAR_W-1:0]      char_code,
    output logic                             last
);

    logic                          radix_mode_reg, radix_mode_next;
    logic                          reg_hit;
    itad_pkg::itad_ctrl_t          ctrl;
    itad_pkg::itad_stat_t          stat;
    logic                          wr_en;
    logic [itad_pkg::CNT_W-1:0]    wr_idx;
    logic [itad_pkg::CNT_W-1:0]    rd_idx;
    logic [itad_pkg::DIGIT_W-1:0]  rd_digit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == itad_pkg::REG_RADIX_MODE);

    always_comb
    begin
        radix_mode_next = radix_mode_reg;
        if (psel && penable && pwrite && pready && reg_hit)
            radix_mode_next = pwdata[0];
    end

    assign prdata = reg_hit ? {{(itad_pkg::DATA_W-1){1'b0}}, radix_mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_mode_reg <= 1'b0;
        else
            radix_mode_reg <= radix_mode_next;
    end

    itad_digit_unit u_digit_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .value (value),
        .stat  (stat)
    );

    itad_digit_store u_digit_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_digit (stat.digit),
        .rd_idx   (rd_idx),
        .rd_digit (rd_digit)
    );

    itad_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .radix_mode (radix_mode_reg),
        .stat       (stat),
        .rd_digit   (rd_digit),
        .ctrl       (ctrl),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .rd_idx     (rd_idx),
        .busy       (busy),
        .char_valid (char_valid),
        .char_code  (char_code),
        .last       (last)
    );

endmodule
